/* rtl/mtp_pkg.sv */
`default_nettype none
package mtp_pkg;

	// fixed geometry of the generator
	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int WORD_W       = 32;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int CNT_W        = $clog2(STATE_WORDS + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// command codes
	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	// recurrence and tempering constants
	localparam word_t MT_MATRIX    = 32'h9908_B0DF;
	localparam word_t MT_INIT_MULT = 32'd1812433253;
	localparam word_t MT_TEMPER_B  = 32'h9D2C_5680;
	localparam word_t MT_TEMPER_C  = 32'hEFC6_0000;
	localparam word_t MT_UPPER     = 32'h8000_0000;
	localparam word_t MT_LOWER     = 32'h7FFF_FFFF;
	localparam word_t DEFAULT_SEED = 32'd5489;

	// address constants
	localparam addr_t LAST_IDX   = addr_t'(STATE_WORDS - 1);
	localparam addr_t FAR_SPLIT  = addr_t'(STATE_WORDS - TWIST_OFFSET);
	localparam addr_t FAR_ADD    = addr_t'(TWIST_OFFSET);
	localparam cnt_t  FULL_COUNT = cnt_t'(STATE_WORDS);

	// output tempering, four shift and xor steps
	function automatic word_t temper(input word_t r);
		word_t t;
		t = r ^ (r >> 11);
		t = t ^ ((t << 7) & MT_TEMPER_B);
		t = t ^ ((t << 15) & MT_TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	// one twisted word from its own, next and far words
	function automatic word_t twist_word(input word_t y, input word_t far);
		word_t t;
		t = far ^ (y >> 1);
		if (y[0]) begin
			t = t ^ MT_MATRIX;
		end
		return t;
	endfunction

endpackage
`default_nettype wire

/* rtl/mersenne_twister_prng.sv */
`default_nettype none
// channel  | signals                          | direction | word
// ---------+----------------------------------+-----------+---------------------------
// in       | in_valid, in_ready, cmd, seed    | to block  | draw or reseed command
// out      | out_valid, out_ready, random_word| from block| one tempered word per draw
// cfg      | cfg_valid, cfg_ready, cfg_data   | to block  | default seed register
//
// a draw runs a read state, then an out state that registers the tempered word
// a reseed writes word 0, then words 1 to 623 by multiply then write (32x32 multiplier)
// a draw needing a twist first takes each word through two reads, far read, write-back
// a draw before any reseed first runs the seeding pass from the default seed
// reset sets sequencer, counters, default seed; the state memory is filled by seeding
// in_ready is low while a command runs; a draw waits while the out register is still full
module mersenne_twister_prng
	import mtp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [31:0] seed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] random_word,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SEED_MUL = 3'd1;
	localparam logic [2:0] ST_SEED_WR = 3'd2;
	localparam logic [2:0] ST_TW_RD   = 3'd3;
	localparam logic [2:0] ST_TW_FAR  = 3'd4;
	localparam logic [2:0] ST_TW_WR   = 3'd5;
	localparam logic [2:0] ST_DR_RD   = 3'd6;
	localparam logic [2:0] ST_DR_OUT  = 3'd7;

	logic [2:0] state_q;
	logic       has_seed_q;
	logic       draw_q;
	logic       out_valid_q;
	addr_t      idx_q;
	cnt_t       wl_q;
	cnt_t       rp_q;
	word_t      default_seed_q;
	word_t      prev_q;
	word_t      y_q;
	word_t      word_q;
	word_t      prod_s1;

	logic       in_accept;
	logic       seed_now;
	logic       out_free;
	word_t      seed_sel;
	word_t      seed_word;
	addr_t      next_idx;
	addr_t      far_addr;
	addr_t      rp_addr;
	logic       we;
	addr_t      waddr;
	word_t      wdata;
	addr_t      raddr_a;
	addr_t      raddr_b;
	word_t      rdata_a;
	word_t      rdata_b;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign random_word = word_q;

	assign in_accept = in_valid && in_ready;
	assign seed_now  = (cmd == CMD_RESEED) || !has_seed_q;
	assign seed_sel  = (cmd == CMD_RESEED) ? seed : default_seed_q;
	assign out_free  = !out_valid_q || out_ready;

	// seed word and address arithmetic for the twist and read positions
	assign seed_word = prod_s1 + {{(WORD_W-ADDR_W){1'b0}}, idx_q};
	assign next_idx  = (idx_q == LAST_IDX) ? '0 : idx_q + addr_t'(1);
	assign far_addr  = (idx_q < FAR_SPLIT) ? idx_q + FAR_ADD : idx_q - FAR_SPLIT;
	assign rp_addr   = (rp_q < FULL_COUNT) ? addr_t'(rp_q) : addr_t'(rp_q - FULL_COUNT);

	// memory port steering
	always_comb begin
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = seed_word;
		raddr_a = idx_q;
		raddr_b = next_idx;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && seed_now) begin
					we    = 1'b1;
					waddr = '0;
					wdata = seed_sel;
				end
			end
			ST_SEED_WR: begin
				we = 1'b1;
			end
			ST_TW_FAR: begin
				raddr_a = far_addr;
			end
			ST_TW_WR: begin
				we    = 1'b1;
				wdata = twist_word(y_q, rdata_a);
			end
			ST_DR_RD, ST_DR_OUT: begin
				raddr_a = rp_addr;
			end
			default: begin
			end
		endcase
	end

	mtp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			has_seed_q     <= 1'b0;
			draw_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			idx_q          <= '0;
			wl_q           <= '0;
			rp_q           <= '0;
			default_seed_q <= DEFAULT_SEED;
		end else begin
			if (cfg_valid && cfg_ready) begin
				default_seed_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != ST_DR_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						draw_q <= (cmd == CMD_DRAW);
						idx_q  <= seed_now ? addr_t'(1) : '0;
						if (seed_now) begin
							state_q <= ST_SEED_MUL;
						end else if (wl_q == '0) begin
							state_q <= ST_TW_RD;
						end else begin
							state_q <= ST_DR_RD;
						end
					end
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_WR;
				end
				ST_SEED_WR: begin
					if (idx_q == LAST_IDX) begin
						has_seed_q <= 1'b1;
						wl_q       <= '0;
						rp_q       <= '0;
						idx_q      <= '0;
						state_q    <= draw_q ? ST_TW_RD : ST_IDLE;
					end else begin
						idx_q   <= idx_q + addr_t'(1);
						state_q <= ST_SEED_MUL;
					end
				end
				ST_TW_RD: begin
					state_q <= ST_TW_FAR;
				end
				ST_TW_FAR: begin
					state_q <= ST_TW_WR;
				end
				ST_TW_WR: begin
					if (idx_q == LAST_IDX) begin
						wl_q    <= FULL_COUNT;
						rp_q    <= '0;
						state_q <= ST_DR_RD;
					end else begin
						idx_q   <= next_idx;
						state_q <= ST_TW_RD;
					end
				end
				ST_DR_RD: begin
					state_q <= ST_DR_OUT;
				end
				ST_DR_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						rp_q        <= rp_q + cnt_t'(1);
						wl_q        <= wl_q - cnt_t'(1);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers: multiplier stage, previous word, twist pair, out word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_accept) begin
			prev_q <= seed_sel;
		end
		if (state_q == ST_SEED_MUL) begin
			prod_s1 <= MT_INIT_MULT * (prev_q ^ (prev_q >> 30));
		end
		if (state_q == ST_SEED_WR) begin
			prev_q <= seed_word;
		end
		if (state_q == ST_TW_FAR) begin
			y_q <= (rdata_a & MT_UPPER) | (rdata_b & MT_LOWER);
		end
		if (state_q == ST_DR_OUT && out_free) begin
			word_q <= temper(rdata_a);
		end
	end

`ifndef NO_ASSERTIONS
	// read position and words left always account for a full block once twisted
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(wl_q != '0) |-> (({1'b0, rp_q} + {1'b0, wl_q}) == (CNT_W+1)'(STATE_WORDS)))
		else $error("read position and words left out of step");

	// a draw never reads the memory with nothing left to hand out
	a_draw_has_words: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DR_RD) |-> (wl_q != '0 && has_seed_q))
		else $error("draw read with empty or unseeded state");

	// memory writes only come from seeding or twisting
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_IDLE || state_q == ST_SEED_WR || state_q == ST_TW_WR))
		else $error("memory written outside seeding or twist");

	// a finished twist always leads straight into the pending draw's read
	a_twist_to_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_WR && idx_q == LAST_IDX) |=> (state_q == ST_DR_RD))
		else $error("twist end did not start the draw");

	// a result is only loaded after the out register has room
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DR_OUT && !out_free) |=> (state_q == ST_DR_OUT))
		else $error("draw left while out register full");
`endif

endmodule
`default_nettype wire

/* rtl/mtp_ram.sv */
`default_nettype none
module mtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire
